### hw/rtl/clads_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clads_pkg: shared types and constants of the CPU load smoother
// Payload structs, register map, reset values and controller interface.
// ----------------------------------------------------------------------------
package clads_pkg;

    localparam int CPU_W         = 4;
    localparam int TICK_W        = 64;
    localparam int LOAD_W        = 17;
    localparam int RATE_W        = 17;
    localparam int HEAT_W        = 8;
    localparam int CPU_SLOTS_DEF = 16;

    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic REG_RISE_GAIN = 1'b0;
    localparam logic REG_FALL_GAIN = 1'b1;

    localparam logic [RATE_W-1:0] RISE_GAIN_RESET = 17'd11469;
    localparam logic [RATE_W-1:0] FALL_GAIN_RESET = 17'd12059;
    localparam logic [LOAD_W-1:0] ONE_Q16         = 17'd65536;
    localparam logic [HEAT_W-1:0] HEAT_SCALE      = 8'd255;

    typedef struct packed {
        logic [CPU_W-1:0]  cpu_index;
        logic [TICK_W-1:0] total_ticks;
        logic [TICK_W-1:0] idle_ticks;
    } in_item_t;

    typedef struct packed {
        logic [CPU_W-1:0]  cpu_number;
        logic [LOAD_W-1:0] raw_load;
        logic [LOAD_W-1:0] smoothed_load;
        logic [HEAT_W-1:0] heat_level;
    } out_item_t;

    typedef struct packed {
        logic [RATE_W-1:0] rise_gain;
        logic [RATE_W-1:0] fall_gain;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic calc_delta;
        logic calc_check;
        logic div_step;
        logic round_q;
        logic mul_smooth;
        logic upd_smooth;
        logic mul_heat;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic use_slot;
        logic special;
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

### hw/rtl/clads_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clads_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module clads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/clads_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clads_regs: configuration registers
// APB-style port holding the attack and decay gains.
// ----------------------------------------------------------------------------
module clads_regs
    import clads_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_RISE_GAIN: cfg_next.rise_gain = pwdata[RATE_W-1:0];
                REG_FALL_GAIN: cfg_next.fall_gain = pwdata[RATE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_gain <= RISE_GAIN_RESET;
            cfg_reg.fall_gain <= FALL_GAIN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RISE_GAIN: prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.rise_gain};
            REG_FALL_GAIN: prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.fall_gain};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/clads_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clads_ctrl: sequencing controller
// Steps one sample through state read, division, smoothing and delivery.
// ----------------------------------------------------------------------------
module clads_ctrl
    import clads_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_READ   = 9'b000000010,
        ST_CHECK  = 9'b000000100,
        ST_DIV    = 9'b000001000,
        ST_ROUND  = 9'b000010000,
        ST_SMUL   = 9'b000100000,
        ST_SADD   = 9'b001000000,
        ST_HMUL   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.calc_delta = 1'b1;
                state_next     = sts.use_slot ? ST_CHECK : ST_FINISH;
            end
            ST_CHECK: begin
                cmd.calc_check = 1'b1;
                state_next     = sts.special ? ST_SMUL : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_q = 1'b1;
                state_next  = ST_SMUL;
            end
            ST_SMUL: begin
                cmd.mul_smooth = 1'b1;
                state_next     = ST_SADD;
            end
            ST_SADD: begin
                cmd.upd_smooth = 1'b1;
                state_next     = ST_HMUL;
            end
            ST_HMUL: begin
                cmd.mul_heat = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/clads_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clads_dpath: datapath of the CPU load smoother
// Per-CPU state RAM, seen flags, serial divider, smoothing and output register.
// ----------------------------------------------------------------------------
module clads_dpath
    import clads_pkg::*;
#(
    parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int INDEX_SPAN  = 2 ** CPU_W;
    localparam int STATE_DEPTH = (CPU_SLOTS < INDEX_SPAN) ? CPU_SLOTS : INDEX_SPAN;
    localparam int ADDR_W      = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
    localparam int ENTRY_W     = 2 * TICK_W + LOAD_W;
    localparam int PROD_W      = LOAD_W + RATE_W;
    localparam int HPROD_W     = LOAD_W + HEAT_W;

    logic [CPU_W-1:0]       cpu_reg;
    logic [TICK_W-1:0]      total_reg, total_next;
    logic [TICK_W-1:0]      idle_reg, idle_next;
    logic                   slot_ok_reg, slot_ok_next;
    logic                   use_reg, use_next;
    logic [TICK_W-1:0]      dt_reg, dt_next;
    logic [TICK_W-1:0]      di_reg, di_next;
    logic [TICK_W-1:0]      rem_reg, rem_next;
    logic [DIV_STEPS-1:0]   q_reg, q_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LOAD_W-1:0]      raw_reg, raw_next;
    logic [LOAD_W-1:0]      s_reg, s_next;
    logic                   rise_reg, rise_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [HPROD_W-1:0]     hprod_reg, hprod_next;
    logic [STATE_DEPTH-1:0] seen_reg, seen_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;
    logic [CPU_W-1:0]       cpu_next;

    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic               in_slot_ok;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_we;
    logic [TICK_W-1:0]  ram_total;
    logic [TICK_W-1:0]  ram_idle;
    logic [LOAD_W-1:0]  ram_smooth;

    logic [TICK_W-1:0]  busy;
    logic               zero_dt;
    logic               sat;
    logic               div_carry;
    logic [TICK_W-1:0]  rem_sh;
    logic               rise;
    logic [RATE_W-1:0]  rate_sel;
    logic [RATE_W-1:0]  rate_c;
    logic [LOAD_W-1:0]  mag;
    logic [LOAD_W-1:0]  step;
    logic [DIV_STEPS:0] q_inc;
    logic [HPROD_W-1:0] heat_sum;

    assign in_addr    = s_data.cpu_index[ADDR_W-1:0];
    assign cur_addr   = cpu_reg[ADDR_W-1:0];
    assign in_slot_ok = ({{(32-CPU_W){1'b0}}, s_data.cpu_index} < CPU_SLOTS);

    assign ram_total  = ram_rdata[ENTRY_W-1 -: TICK_W];
    assign ram_idle   = ram_rdata[LOAD_W +: TICK_W];
    assign ram_smooth = ram_rdata[LOAD_W-1:0];
    assign ram_wdata  = {total_reg, idle_reg, s_reg};
    assign ram_we     = cmd.finish && slot_ok_reg;

    clads_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STATE_DEPTH)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(cur_addr),
        .wdata(ram_wdata),
        .re   (cmd.load_in),
        .raddr(in_addr),
        .rdata(ram_rdata)
    );

    assign busy      = dt_reg - di_reg;
    assign zero_dt   = (dt_reg == '0);
    assign sat       = (busy >= dt_reg);
    assign div_carry = rem_reg[TICK_W-1];
    assign rem_sh    = {rem_reg[TICK_W-2:0], 1'b0};

    assign rise     = (s_reg < raw_reg);
    assign rate_sel = rise ? cfg.rise_gain : cfg.fall_gain;
    assign rate_c   = (rate_sel > ONE_Q16) ? ONE_Q16 : rate_sel;
    assign mag      = rise ? (raw_reg - s_reg) : (s_reg - raw_reg);
    assign step     = LOAD_W'((prod_reg + PROD_W'(32768)) >> 16);
    assign q_inc    = {1'b0, q_reg} + (DIV_STEPS+1)'(1);
    assign heat_sum = hprod_reg + HPROD_W'(32768);

    always_comb begin
        cpu_next     = cpu_reg;
        total_next   = total_reg;
        idle_next    = idle_reg;
        slot_ok_next = slot_ok_reg;
        use_next     = use_reg;
        dt_next      = dt_reg;
        di_next      = di_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        raw_next     = raw_reg;
        s_next       = s_reg;
        rise_next    = rise_reg;
        prod_next    = prod_reg;
        hprod_next   = hprod_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cmd.load_in) begin
            cpu_next     = s_data.cpu_index;
            total_next   = s_data.total_ticks;
            idle_next    = s_data.idle_ticks;
            slot_ok_next = in_slot_ok;
            use_next     = in_slot_ok && seen_reg[in_addr];
            raw_next     = '0;
            s_next       = '0;
            hprod_next   = '0;
        end
        if (cmd.calc_delta) begin
            dt_next = total_reg - ram_total;
            di_next = idle_reg - ram_idle;
            s_next  = use_reg ? ram_smooth : '0;
        end
        if (cmd.calc_check) begin
            rem_next = busy;
            q_next   = '0;
            cnt_next = '0;
            raw_next = zero_dt ? '0 : ONE_Q16;
        end
        if (cmd.div_step) begin
            if (div_carry || (rem_sh >= dt_reg)) begin
                rem_next = rem_sh - dt_reg;
                q_next   = {q_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.round_q) begin
            raw_next = q_inc[DIV_STEPS:1];
        end
        if (cmd.mul_smooth) begin
            rise_next = rise;
            prod_next = PROD_W'(mag) * PROD_W'(rate_c);
        end
        if (cmd.upd_smooth) begin
            s_next = rise_reg ? (s_reg + step) : (s_reg - step);
        end
        if (cmd.mul_heat) begin
            hprod_next = HPROD_W'(s_reg) * HPROD_W'(HEAT_SCALE);
        end
        if (cmd.finish) begin
            if (slot_ok_reg) begin
                seen_next[cur_addr] = 1'b1;
            end
            m_valid_next              = 1'b1;
            m_data_next.cpu_number    = cpu_reg;
            m_data_next.raw_load      = raw_reg;
            m_data_next.smoothed_load = s_reg;
            m_data_next.heat_level    = heat_sum[16 +: HEAT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cpu_reg     <= cpu_next;
        total_reg   <= total_next;
        idle_reg    <= idle_next;
        slot_ok_reg <= slot_ok_next;
        use_reg     <= use_next;
        dt_reg      <= dt_next;
        di_reg      <= di_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        raw_reg     <= raw_next;
        s_reg       <= s_next;
        rise_reg    <= rise_next;
        prod_reg    <= prod_next;
        hprod_reg   <= hprod_next;
        m_data_reg  <= m_data_next;
    end

    assign sts.use_slot = use_reg;
    assign sts.special  = zero_dt || sat;
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_busy = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/cpu_load_attack_decay_smoother_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_load_attack_decay_smoother_top: per-CPU load smoother
// Turns cumulative tick counters into raw, smoothed and heat load values.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  in_item_t  (cpu, total, idle ticks)
//  m_       out        m_valid / m_ready  out_item_t (cpu, raw, smoothed, heat)
//  apb      in         psel / penable     rise and fall gains
//
//  A sample with history runs through the restoring divider; a zero or
//  saturated delta skips it, and a first sample or an unused CPU index goes
//  straight from the state read to the result. One sample is in work at a time;
//  s_ready is high only while idle. Synchronous reset clears the seen flags.
//  A stalled result waits in the output register while the next sample is
//  accepted; that sample then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module cpu_load_attack_decay_smoother_top
    import clads_pkg::*;
#(
    parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    clads_regs u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    clads_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    clads_dpath #(
        .CPU_SLOTS(CPU_SLOTS)
    ) u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

### test/tb_cpu_load_attack_decay_smoother_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_load_attack_decay_smoother_top: self-checking bench of the smoother
// Drives counter samples through the valid/ready input channel and checks every
// result against a per-CPU load predictor. A directed table covers first
// samples, zero and saturated deltas, counter wrap and the gain extremes; five
// random phases follow, each under its own pair of gains written over APB.
// ----------------------------------------------------------------------------
module tb_cpu_load_attack_decay_smoother_top;
    import clads_pkg::*;

    localparam int ITEMS_PER_PHASE = 280;
    localparam int PHASES          = 5;
    localparam int N_ROWS          = 25;
    localparam int DRAIN_CYCLES    = 30;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // In a configuration row the tick fields carry the attack and decay gains.
    typedef struct packed {
        row_kind_t          kind;
        logic [CPU_W-1:0]   cpu;
        logic [TICK_W-1:0]  total;
        logic [TICK_W-1:0]  idle;
        logic               typed;
        logic [LOAD_W-1:0]  raw;
        logic [LOAD_W-1:0]  smoothed;
        logic [HEAT_W-1:0]  heat;
    } stim_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic [TICK_W-1:0]  prev_total [CPU_SLOTS_DEF];
    logic [TICK_W-1:0]  prev_idle  [CPU_SLOTS_DEF];
    logic [LOAD_W-1:0]  smooth_q   [CPU_SLOTS_DEF];
    logic               seen_cpu   [CPU_SLOTS_DEF];
    logic [RATE_W-1:0]  gain_attack;
    logic [RATE_W-1:0]  gain_decay;

    logic [TICK_W-1:0]  stim_total [CPU_SLOTS_DEF];
    logic [TICK_W-1:0]  stim_idle  [CPU_SLOTS_DEF];

    out_item_t          pending_loads [$];
    out_item_t          want;
    int                 mismatches = 0;
    bit                 no_stall   = 1'b0;
    int unsigned        stall_left = 0;
    int unsigned        stall_pick;
    stim_row_t          rows [N_ROWS];

    cpu_load_attack_decay_smoother_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic out_item_t predict_load(in_item_t it);
        logic [TICK_W-1:0] dt;
        logic [TICK_W-1:0] di;
        logic [TICK_W-1:0] busy;
        logic [80:0]       quo;
        logic [17:0]       q1;
        logic [17:0]       step;
        logic [33:0]       prod;
        logic [24:0]       heat_w;
        logic [LOAD_W-1:0] raw;
        logic [LOAD_W-1:0] s;
        logic [LOAD_W-1:0] mag;
        logic [RATE_W-1:0] rate;
        logic              rising;
        int                k;
        out_item_t         r;
        k   = int'(it.cpu_index);
        raw = '0;
        s   = '0;
        if (seen_cpu[k]) begin
            dt   = it.total_ticks - prev_total[k];
            di   = it.idle_ticks - prev_idle[k];
            busy = dt - di;
            if (dt == '0) begin
                raw = '0;
            end else if (busy >= dt) begin
                raw = ONE_Q16;
            end else begin
                quo = {busy, 17'd0} / {17'd0, dt};
                q1  = quo[17:0] + 18'd1;
                raw = q1[17:1];
            end
            s      = smooth_q[k];
            rising = s < raw;
            rate   = rising ? gain_attack : gain_decay;
            if (rate > ONE_Q16) begin
                rate = ONE_Q16;
            end
            mag  = rising ? raw - s : s - raw;
            prod = 34'(mag) * 34'(rate) + 34'd32768;
            step = prod[33:16];
            s    = rising ? s + step[16:0] : s - step[16:0];
            smooth_q[k] = s;
        end else begin
            seen_cpu[k] = 1'b1;
        end
        prev_total[k]   = it.total_ticks;
        prev_idle[k]    = it.idle_ticks;
        heat_w          = 25'(s) * 25'(HEAT_SCALE) + 25'd32768;
        r.cpu_number    = it.cpu_index;
        r.raw_load      = raw;
        r.smoothed_load = s;
        r.heat_level    = heat_w[23:16];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (no_stall || p < 60) begin
            return 0;
        end else if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        while (pending_loads.size() != 0) @(posedge aclk);
    endtask

    task automatic write_rate(input logic idx, input logic [RATE_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_RISE_GAIN) begin
            gain_attack = value;
        end else begin
            gain_decay = value;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] d);
        wait_drain();
        write_rate(REG_RISE_GAIN, a);
        write_rate(REG_FALL_GAIN, d);
    endtask

    always @(posedge aclk) begin
        if (no_stall) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 25) begin
                stall_left <= $urandom_range(1, 3);
            end else if (stall_pick < 28) begin
                stall_left <= $urandom_range(10, 50);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_loads.size() == 0) begin
                $error("result for cpu %0d with no transaction outstanding",
                       m_data.cpu_number);
                mismatches++;
            end else begin
                want = pending_loads.pop_front();
                if (m_data.cpu_number !== want.cpu_number) begin
                    $error("cpu_number: expected %0d, actual %0d",
                           want.cpu_number, m_data.cpu_number);
                    mismatches++;
                end
                if (m_data.raw_load !== want.raw_load) begin
                    $error("raw_load: expected %0d, actual %0d",
                           want.raw_load, m_data.raw_load);
                    mismatches++;
                end
                if (m_data.smoothed_load !== want.smoothed_load) begin
                    $error("smoothed_load: expected %0d, actual %0d",
                           want.smoothed_load, m_data.smoothed_load);
                    mismatches++;
                end
                if (m_data.heat_level !== want.heat_level) begin
                    $error("heat_level: expected %0d, actual %0d",
                           want.heat_level, m_data.heat_level);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("cpu_load_attack_decay_smoother_top: mismatch");
        $finish;
    end

    initial begin
        in_item_t          it;
        out_item_t         exp;
        logic [TICK_W-1:0] dt;
        logic [TICK_W-1:0] di;
        logic [TICK_W-1:0] tot;
        logic [TICK_W-1:0] idl;
        logic [RATE_W-1:0] ra;
        logic [RATE_W-1:0] rd;
        int unsigned       gap;
        int unsigned       pick;
        int unsigned       span;
        int                cpu;
        int                nxt;
        bit                pause;
        bit                lower;

        for (int c = 0; c < CPU_SLOTS_DEF; c++) begin
            prev_total[c] = '0;
            prev_idle[c]  = '0;
            smooth_q[c]   = '0;
            seen_cpu[c]   = 1'b0;
            stim_total[c] = '0;
            stim_idle[c]  = '0;
        end
        gain_attack = RISE_GAIN_RESET;
        gain_decay  = FALL_GAIN_RESET;

        rows[0]  = '{ROW_ITEM, 4'd0,  64'd100,  64'd40,   1'b1, 17'd0, 17'd0, 8'd0};
        rows[1]  = '{ROW_ITEM, 4'd15, TICK_MAX, TICK_MAX, 1'b1, 17'd0, 17'd0, 8'd0};
        rows[2]  = '{ROW_ITEM, 4'd0,  64'd100,  64'd40,   1'b1, 17'd0, 17'd0, 8'd0};
        rows[3]  = '{ROW_ITEM, 4'd0,  64'd200,  64'd40,   1'b0, 17'd0, 17'd0, 8'd0};
        rows[4]  = '{ROW_ITEM, 4'd0,  64'd300,  64'd240,  1'b0, 17'd0, 17'd0, 8'd0};
        rows[5]  = '{ROW_ITEM, 4'd0,  64'd400,  64'd340,  1'b0, 17'd0, 17'd0, 8'd0};
        rows[6]  = '{ROW_ITEM, 4'd15, 64'd99,   64'd49,   1'b0, 17'd0, 17'd0, 8'd0};
        rows[7]  = '{ROW_ITEM, 4'd1,  64'd0,    64'd0,    1'b1, 17'd0, 17'd0, 8'd0};
        rows[8]  = '{ROW_ITEM, 4'd1,  TICK_MAX, 64'd1,    1'b0, 17'd0, 17'd0, 8'd0};
        rows[9]  = '{ROW_ITEM, 4'd1,  64'd2,    64'd3,    1'b0, 17'd0, 17'd0, 8'd0};
        rows[10] = '{ROW_ITEM, 4'd1,  64'd5,    64'd4,    1'b0, 17'd0, 17'd0, 8'd0};
        rows[11] = '{ROW_CFG,  4'd0,  64'd65536, 64'd65536, 1'b0, 17'd0, 17'd0, 8'd0};
        rows[12] = '{ROW_ITEM, 4'd2,  64'd0,    TICK_MAX, 1'b1, 17'd0, 17'd0, 8'd0};
        rows[13] = '{ROW_ITEM, 4'd2,  64'd1000, TICK_MAX, 1'b1, 17'd65536, 17'd65536, 8'd255};
        rows[14] = '{ROW_ITEM, 4'd2,  64'd2000, 64'd999,  1'b1, 17'd0, 17'd0, 8'd0};
        rows[15] = '{ROW_CFG,  4'd0,  64'd0,    64'd0,    1'b0, 17'd0, 17'd0, 8'd0};
        rows[16] = '{ROW_ITEM, 4'd0,  64'd500,  64'd340,  1'b0, 17'd0, 17'd0, 8'd0};
        rows[17] = '{ROW_ITEM, 4'd0,  64'd600,  64'd440,  1'b0, 17'd0, 17'd0, 8'd0};
        rows[18] = '{ROW_CFG,  4'd0,  64'd131071, 64'd65537, 1'b0, 17'd0, 17'd0, 8'd0};
        rows[19] = '{ROW_ITEM, 4'd3,  64'd0,    64'd0,    1'b1, 17'd0, 17'd0, 8'd0};
        rows[20] = '{ROW_ITEM, 4'd3,  64'd64,   64'd0,    1'b1, 17'd65536, 17'd65536, 8'd255};
        rows[21] = '{ROW_ITEM, 4'd3,  64'd128,  64'd64,   1'b1, 17'd0, 17'd0, 8'd0};
        rows[22] = '{ROW_CFG,  4'd0,  64'd1,    64'd65535, 1'b0, 17'd0, 17'd0, 8'd0};
        rows[23] = '{ROW_ITEM, 4'd0,  64'd700,  64'd450,  1'b0, 17'd0, 17'd0, 8'd0};
        rows[24] = '{ROW_ITEM, 4'd15, TICK_MAX, 64'd0,    1'b0, 17'd0, 17'd0, 8'd0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (rows[i].kind == ROW_CFG) begin
                set_rates(rows[i].total[RATE_W-1:0], rows[i].idle[RATE_W-1:0]);
            end else begin
                it.cpu_index   = rows[i].cpu;
                it.total_ticks = rows[i].total;
                it.idle_ticks  = rows[i].idle;
                send_sample(it);
                exp = predict_load(it);
                if (rows[i].typed) begin
                    exp.raw_load      = rows[i].raw;
                    exp.smoothed_load = rows[i].smoothed;
                    exp.heat_level    = rows[i].heat;
                end
                pending_loads.push_back(exp);
                gap = pick_gap();
                nxt = (i + 1 < N_ROWS) ? i + 1 : i;
                if (gap != 0 || i == N_ROWS - 1 || rows[nxt].kind == ROW_CFG) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    ra = RISE_GAIN_RESET;
                    rd = FALL_GAIN_RESET;
                end
                1: begin
                    ra = RATE_W'($urandom_range(0, 65536));
                    rd = RATE_W'($urandom_range(0, 65536));
                end
                2: begin
                    ra = ONE_Q16;
                    rd = '0;
                end
                3: begin
                    ra = RATE_W'($urandom_range(65537, 131071));
                    rd = RATE_W'($urandom_range(0, 131071));
                end
                default: begin
                    ra = '0;
                    rd = ONE_Q16;
                end
            endcase
            set_rates(ra, rd);
            no_stall = (p == 2);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                cpu  = int'($urandom_range(0, CPU_SLOTS_DEF - 1));
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    tot = {$urandom, $urandom};
                    idl = {$urandom, $urandom};
                end else begin
                    if (pick < 10) begin
                        dt = '0;
                        di = TICK_W'($urandom_range(0, 3));
                    end else if (pick < 20) begin
                        dt = {$urandom, $urandom};
                        di = {$urandom, $urandom};
                    end else begin
                        span = $urandom_range(1, 5000);
                        dt   = TICK_W'(span);
                        if (pick < 28) begin
                            di = TICK_W'(span + $urandom_range(1, 100));
                        end else begin
                            di = TICK_W'($urandom_range(0, span));
                        end
                    end
                    tot = stim_total[cpu] + dt;
                    idl = stim_idle[cpu] + di;
                end
                stim_total[cpu] = tot;
                stim_idle[cpu]  = idl;

                it.cpu_index   = CPU_W'(cpu);
                it.total_ticks = tot;
                it.idle_ticks  = idl;
                send_sample(it);
                pending_loads.push_back(predict_load(it));

                gap   = pick_gap();
                pause = (p == 1 && k == ITEMS_PER_PHASE / 2) || ($urandom_range(0, 199) == 0);
                lower = gap != 0 || pause || k == ITEMS_PER_PHASE - 1;
                if (lower) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    if (pause) begin
                        wait_drain();
                    end
                end
            end
        end

        no_stall = 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_loads.size() == 0) begin
            $display("cpu_load_attack_decay_smoother_top: match");
        end else begin
            $display("cpu_load_attack_decay_smoother_top: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/clads_pkg.sv
hw/rtl/clads_ram.sv
hw/rtl/clads_regs.sv
hw/rtl/clads_ctrl.sv
hw/rtl/clads_dpath.sv
hw/rtl/cpu_load_attack_decay_smoother_top.sv
test/tb_cpu_load_attack_decay_smoother_top.sv
